### rtl/core/rclli_pkg.sv
// ----------------------------------------------------------------------------
// RC/LAN interlock package
// Shared types, state codes and register reset values.
// ----------------------------------------------------------------------------
package rclli_pkg;

   // Channel bound for the watched-channel check
   localparam logic [4:0] MAX_CHANNELS = 5'd14;

   // Register indexes on the configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INTERLOCK_ENABLED   = 2'd0,
      CSR_WATCHED_CHANNEL     = 2'd1,
      CSR_ACTIVE_MAX_PULSE_US = 2'd2,
      CSR_CONFIRM_FRAMES      = 2'd3
   } csr_index_type;

   // Shown / committed / pending state codes
   typedef enum logic [2:0] {
      ST_DISABLED  = 3'd0,
      ST_NOSIG     = 3'd1,
      ST_FAILSAFE  = 3'd2,
      ST_PRIORITY  = 3'd3,
      ST_LOST      = 3'd4,
      ST_UNAVAIL   = 3'd5,
      ST_PRIO_CAND = 3'd6,
      ST_FS_CAND   = 3'd7
   } mode_type;

   typedef struct packed {
      logic        interlock_enabled;
      logic [3:0]  watched_channel;
      logic [15:0] active_max_pulse_us;
      logic [7:0]  confirm_frames;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      interlock_enabled:   1'b0,
      watched_channel:     4'd5,
      active_max_pulse_us: 16'd1500,
      confirm_frames:      8'd3
   };

   typedef struct packed {
      mode_type    display_state;
      mode_type    committed_mode;
      mode_type    pending_mode;
      logic [7:0]  pending_count;
      logic [31:0] priority_epoch_count;
      logic [31:0] last_frame_seq;
   } state_type;

   typedef struct packed {
      logic        receiver_present;
      logic        signal_ok;
      logic        channels_present;
      logic [3:0]  channel_total;
      logic [15:0] selected_pulse_us;
      logic [31:0] frame_seq;
   } req_item_type;

   typedef struct packed {
      mode_type    shown_state;
      logic        lan_permit;
      logic [15:0] pulse_us_out;
      logic [31:0] epoch_out;
      logic [7:0]  confirm_count_out;
      logic [7:0]  confirm_needed_out;
   } rsp_item_type;

   // State right after reset or any register write
   function automatic state_type reinit_state(input logic enabled);
      state_type s;
      s.display_state        = enabled ? ST_NOSIG : ST_DISABLED;
      s.committed_mode       = s.display_state;
      s.pending_mode         = ST_DISABLED;
      s.pending_count        = 8'd0;
      s.priority_epoch_count = 32'd0;
      s.last_frame_seq       = 32'd0;
      return s;
   endfunction

   // Register set that lets the block produce results
   function automatic logic cfg_valid(input cfg_type c);
      return !c.interlock_enabled ||
             (c.watched_channel != 4'd0 &&
              {1'b0, c.watched_channel} <= MAX_CHANNELS &&
              c.active_max_pulse_us != 16'd0 &&
              c.confirm_frames != 8'd0);
   endfunction

endpackage

### rtl/core/rc_link_lan_interlock_unit.sv
// ----------------------------------------------------------------------------
// RC/LAN interlock unit
// Arbitrates between radio (PPM) priority and LAN control from receiver items.
// ----------------------------------------------------------------------------
// Each req item is one receiver observation. It is captured in an input
// register, classified by a single pass of comparison logic against the
// interlock state, and the result lands in an output register once that
// register is free; rsp_valid rises as the result is registered there. One
// item can be taken every cycle, limited only by rsp_stall. When
// interlock_enabled is 1 and the other registers are out of range
// (watched channel 0 or above 14, zero pulse limit, zero confirm count)
// items are still taken but yield no result. Any csr write resets the
// interlock state just like reset; write registers only while no item is in
// flight. csr_ready is always high.
// ----------------------------------------------------------------------------
module rc_link_lan_interlock_unit import rclli_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   // observation items
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_item_type            req_item,
   // result items
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_item_type            rsp_item,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   cfg_type      cfg_ff, cfg_in;
   state_type    state_ff, state_in, state_nxt;
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;
   rsp_item_type step_result;
   logic         csr_write;
   logic         out_free;
   logic         s1_take;
   logic         produce;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Register file
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_INTERLOCK_ENABLED:   cfg_in.interlock_enabled   = csr_data[0];
            CSR_WATCHED_CHANNEL:     cfg_in.watched_channel     = csr_data[3:0];
            CSR_ACTIVE_MAX_PULSE_US: cfg_in.active_max_pulse_us = csr_data[15:0];
            CSR_CONFIRM_FRAMES:      cfg_in.confirm_frames      = csr_data[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   // Pipeline control: output register frees when empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_take   = s1_valid_ff && out_free;
   assign produce   = s1_take && cfg_valid(cfg_ff);
   assign req_stall = s1_valid_ff && !out_free;

   assign s1_valid_in  = (req_valid && !req_stall) ? 1'b1 :
                         (s1_take ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = produce ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   rclli_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (s1_item_ff),
      .state_nxt (state_nxt),
      .result    (step_result)
   );

   // Register write re-initializes; otherwise state advances per produced item
   always_comb begin
      state_in = state_ff;
      if (csr_write) begin
         state_in = reinit_state(cfg_in.interlock_enabled);
      end else if (produce) begin
         state_in = state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         state_ff     <= reinit_state(CFG_RESET.interlock_enabled);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_item_ff <= req_item;
      end
      if (produce) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### rtl/core/rclli_step.sv
// ----------------------------------------------------------------------------
// RC/LAN interlock step
// Classifies one observation and computes the next state and the result item.
// ----------------------------------------------------------------------------
module rclli_step import rclli_pkg::*; (
   input  cfg_type      cfg,
   input  state_type    state_cur,
   input  req_item_type item,
   output state_type    state_nxt,
   output rsp_item_type result
);

   mode_type    next_mode;
   mode_type    auth_mode;
   logic [15:0] used_pulse;
   logic        fresh;
   logic [7:0]  count_inc;

   // Classification of the observation
   always_comb begin
      next_mode  = ST_DISABLED;
      used_pulse = 16'd0;
      if (cfg.interlock_enabled) begin
         if (!item.receiver_present || !item.signal_ok) begin
            next_mode = (state_cur.priority_epoch_count != 32'd0) ? ST_LOST : ST_NOSIG;
         end else if (!item.channels_present ||
                      item.channel_total < cfg.watched_channel) begin
            next_mode = ST_UNAVAIL;
         end else begin
            used_pulse = item.selected_pulse_us;
            next_mode  = (item.selected_pulse_us <= cfg.active_max_pulse_us) ?
                         ST_PRIORITY : ST_FAILSAFE;
         end
      end
   end

   assign fresh = item.signal_ok && item.frame_seq != 32'd0 &&
                  item.frame_seq != state_cur.last_frame_seq;

   // Candidate count, saturating
   always_comb begin
      if (state_cur.pending_mode == next_mode) begin
         count_inc = (state_cur.pending_count == 8'hFF) ?
                     state_cur.pending_count : state_cur.pending_count + 8'd1;
      end else begin
         count_inc = 8'd1;
      end
   end

   always_comb begin
      state_nxt = state_cur;
      if (fresh) begin
         state_nxt.last_frame_seq = item.frame_seq;
      end
      priority if (!cfg.interlock_enabled) begin
         state_nxt.committed_mode = next_mode;
         state_nxt.pending_mode   = next_mode;
         state_nxt.pending_count  = 8'd0;
         state_nxt.display_state  = next_mode;
      end else if (next_mode == ST_NOSIG || next_mode == ST_LOST ||
                   next_mode == ST_UNAVAIL) begin
         state_nxt.pending_count = 8'd0;
         state_nxt.pending_mode  = state_cur.committed_mode;
         state_nxt.display_state = next_mode;
      end else if (next_mode == state_cur.committed_mode) begin
         state_nxt.pending_count = 8'd0;
         state_nxt.pending_mode  = next_mode;
         state_nxt.display_state = next_mode;
      end else if (fresh) begin
         state_nxt.pending_mode  = next_mode;
         state_nxt.pending_count = count_inc;
         if (count_inc >= cfg.confirm_frames) begin
            if (next_mode == ST_PRIORITY && state_cur.committed_mode != ST_PRIORITY) begin
               state_nxt.priority_epoch_count = state_cur.priority_epoch_count + 32'd1;
            end
            state_nxt.committed_mode = next_mode;
            state_nxt.pending_count  = 8'd0;
            state_nxt.display_state  = next_mode;
         end else begin
            state_nxt.display_state = (next_mode == ST_PRIORITY) ? ST_PRIO_CAND : ST_FS_CAND;
         end
      end else if (state_cur.pending_count == 8'd0) begin
         state_nxt.display_state = state_cur.committed_mode;
      end
   end

   // Candidates defer to the committed mode for LAN authority
   assign auth_mode = (state_nxt.display_state == ST_PRIO_CAND ||
                       state_nxt.display_state == ST_FS_CAND) ?
                      state_nxt.committed_mode : state_nxt.display_state;

   always_comb begin
      result.shown_state        = state_nxt.display_state;
      result.lan_permit         = (auth_mode == ST_DISABLED || auth_mode == ST_NOSIG ||
                                   auth_mode == ST_FAILSAFE || auth_mode == ST_LOST);
      result.pulse_us_out       = used_pulse;
      result.epoch_out          = state_nxt.priority_epoch_count;
      result.confirm_count_out  = state_nxt.pending_count;
      result.confirm_needed_out = cfg.confirm_frames;
   end

endmodule

### rtl/core/rclli_checker.sv
// ----------------------------------------------------------------------------
// RC/LAN interlock checker
// Port-level properties of the interlock unit, bound to the top level.
// ----------------------------------------------------------------------------
module rclli_checker import rclli_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   // A pending result survives a stall
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // LAN permission is denied while priority or unavailable is shown
   a_lan_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.shown_state == ST_PRIORITY ||
                    rsp_item.shown_state == ST_UNAVAIL) |-> !rsp_item.lan_permit)
      else $error("LAN allowed under priority or unavailable");

   // No pulse reported when the channel was not read
   a_pulse_unread: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.shown_state == ST_LOST || rsp_item.shown_state == ST_UNAVAIL ||
                    rsp_item.shown_state == ST_DISABLED) |-> rsp_item.pulse_us_out == 16'd0)
      else $error("pulse reported for an unread channel");

   // Confirmation count only runs while a candidate is shown
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.shown_state != ST_PRIO_CAND &&
      rsp_item.shown_state != ST_FS_CAND |-> rsp_item.confirm_count_out == 8'd0)
      else $error("confirmation count nonzero outside a candidate state");

endmodule

bind rc_link_lan_interlock_unit rclli_checker u_rclli_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);
